/* rtl/core/video_port_and_line_irq_core_defines.svh */
// Assertion macros shared by the core RTL files.
// Each macro expects clk_i and rst_ni to be visible in the asserting module.
`ifndef VIDEO_PORT_AND_LINE_IRQ_CORE_DEFINES_SVH
`define VIDEO_PORT_AND_LINE_IRQ_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vplirq_pkg.sv */
// Shared types and constants for the video port and line interrupt core.
// No dependencies; imported by the top level and vplirq_ctrl.
package vplirq_pkg;

  localparam int VIDEO_MEM_DEPTH = 16384;
  localparam int COLOR_MEM_DEPTH = 64;
  localparam int LINES_PER_FRAME = 262;

  localparam int VA_W   = $clog2(VIDEO_MEM_DEPTH);
  localparam int CA_W   = $clog2(COLOR_MEM_DEPTH);
  localparam int LINE_W = $clog2(LINES_PER_FRAME);

  localparam int VPTR_W = 14;
  localparam int CPTR_W = 6;

  localparam logic [VPTR_W-1:0] VPTR_MASK    = 14'h3FFF;
  localparam logic [CPTR_W-1:0] CMASK_WIDE   = 6'h3F;
  localparam logic [CPTR_W-1:0] CMASK_NARROW = 6'h1F;

  localparam logic [LINE_W-1:0] LINE_LAST       = LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [LINE_W-1:0] LINE_FRAME      = LINE_W'(192);
  localparam logic [LINE_W-1:0] LINE_VBLANK     = LINE_W'(193);
  localparam logic [LINE_W-1:0] LINE_VBLANK_END = LINE_W'(224);

  typedef enum logic [2:0] {
    CMD_DATA_RD   = 3'd0,
    CMD_DATA_WR   = 3'd1,
    CMD_STATUS_RD = 3'd2,
    CMD_CTRL_WR   = 3'd3,
    CMD_LINE_TICK = 3'd4
  } cmd_e;

  typedef struct packed {
    logic            en;
    logic            we;
    logic [VA_W-1:0] addr;
    logic [7:0]      wdata;
  } vram_req_t;

  typedef struct packed {
    logic            en;
    logic            we;
    logic [CA_W-1:0] addr;
    logic [7:0]      wdata;
  } cram_req_t;

  typedef struct packed {
    logic [7:0]        rd;
    logic              color_rd;
    logic              irq;
    logic [LINE_W-1:0] line;
  } result_t;

endpackage

/* rtl/core/video_port_and_line_irq_core.sv */
// Video port and line interrupt core, top level.
// Pipeline: memory stage register, then output register; both stall on out_ready_i.
// Throughput: one transaction per cycle unless stalled; single-port video RAM sets it.
// Reset: control state clears at once, then a sweep writes zero to all 16384 video
// memory entries, one per cycle, with in_ready_o low; color memory uses valid bits.
// Depends on vplirq_pkg, vplirq_ram, vplirq_ctrl and the shared assertion macros.
`include "video_port_and_line_irq_core_defines.svh"

module video_port_and_line_irq_core
  import vplirq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [7:0]        data_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              irq_asserted_o,
  output logic [LINE_W-1:0] current_line_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [VA_W-1:0] CLR_LAST = VA_W'(VIDEO_MEM_DEPTH - 1);

  logic            handheld_q;
  logic            clr_busy_q;
  logic [VA_W-1:0] clr_cnt_q;

  logic            acc;
  logic            adv;
  vram_req_t       vreq;
  cram_req_t       creq;
  result_t         res;
  logic [7:0]      vram_rdata;
  logic [7:0]      cram_rdata;
  logic            vram_en;
  logic            vram_we;
  logic [VA_W-1:0] vram_addr;
  logic [7:0]      vram_wdata;

  logic [COLOR_MEM_DEPTH-1:0] cvalid_q;

  logic       s1_valid_q;
  result_t    s1_q;
  logic       s1_cvalid_q;
  logic       out_valid_q;
  logic [7:0] out_rd_q;
  logic       out_irq_q;
  logic [LINE_W-1:0] out_line_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, handheld_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handheld_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      handheld_q <= pwdata[0];
    end
  end

  // Video memory clearing sweep after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + VA_W'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || adv);
  assign acc        = in_valid_i && in_ready_o;

  vplirq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .cmd_i        (cmd_i),
    .data_i       (data_in_i),
    .handheld_i   (handheld_q),
    .vram_rdata_i (vram_rdata),
    .vram_req_o   (vreq),
    .cram_req_o   (creq),
    .result_o     (res)
  );

  assign vram_en    = clr_busy_q || vreq.en;
  assign vram_we    = clr_busy_q || vreq.we;
  assign vram_addr  = clr_busy_q ? clr_cnt_q : vreq.addr;
  assign vram_wdata = clr_busy_q ? 8'd0 : vreq.wdata;

  vplirq_ram #(
    .DEPTH (VIDEO_MEM_DEPTH),
    .WIDTH (8)
  ) u_vram (
    .clk_i   (clk_i),
    .en_i    (vram_en),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i (vram_wdata),
    .rdata_o (vram_rdata)
  );

  vplirq_ram #(
    .DEPTH (COLOR_MEM_DEPTH),
    .WIDTH (8)
  ) u_cram (
    .clk_i   (clk_i),
    .en_i    (creq.en),
    .we_i    (creq.we),
    .addr_i  (creq.addr),
    .wdata_i (creq.wdata),
    .rdata_o (cram_rdata)
  );

  // A color entry that was never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (creq.en && creq.we) begin
      cvalid_q[creq.addr] <= 1'b1;
    end
  end

  // Memory stage: holds the transaction while the memory output is pending.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q        <= res;
      s1_cvalid_q <= cvalid_q[creq.addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_rd_q   <= s1_q.color_rd ? (s1_cvalid_q ? cram_rdata : 8'd0) : s1_q.rd;
      out_irq_q  <= s1_q.irq;
      out_line_q <= s1_q.line;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign irq_asserted_o = out_irq_q;
  assign current_line_o = out_line_q;

  `VPL_ASSERT_IMP(a_no_accept_clearing, clr_busy_q, !in_ready_o, "transaction accepted during memory clear")
  `VPL_ASSERT_IMP(a_full_pipe_stalls, s1_valid_q && out_valid_q && !out_ready_i, !in_ready_o, "input accepted while both stages are stalled")
  `VPL_ASSERT_IMP(a_clear_ends_at_last, $fell(clr_busy_q), $past(clr_cnt_q) == CLR_LAST, "memory clear ended early")

endmodule

/* rtl/core/vplirq_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// Standalone; used for the video and color memories of the core.
module vplirq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/vplirq_ctrl.sv */
// Port control state: pointers, write latch, read-ahead buffer, flags, line counter.
// Depends on vplirq_pkg and the shared assertion macros.
`include "video_port_and_line_irq_core_defines.svh"

module vplirq_ctrl
  import vplirq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_i,
  input  logic        handheld_i,
  input  logic [7:0]  vram_rdata_i,
  output vram_req_t   vram_req_o,
  output cram_req_t   cram_req_o,
  output result_t     result_o
);

  logic              pend_q, pend_d;
  logic [7:0]        latch_q, latch_d;
  logic              frame_q, frame_d;
  logic              line_q, line_d;
  logic [7:0]        rab_q, rab_d;
  logic              rab_mem_q, rab_mem_d;
  logic              cmode_q, cmode_d;
  logic [CPTR_W-1:0] cptr_q, cptr_d;
  logic [VPTR_W-1:0] vptr_q, vptr_d;
  logic [LINE_W-1:0] lc_q, lc_d;
  logic [7:0]        lui_q, lui_d;
  logic              irq_q, irq_d;
  logic              r0_b4_q, r0_b4_d;
  logic              r1_b5_q, r1_b5_d;
  logic [7:0]        r10_q, r10_d;

  logic [CPTR_W-1:0] cmask;
  logic [CPTR_W-1:0] cptr_inc;
  logic [VPTR_W-1:0] vptr_inc;
  logic [VPTR_W-1:0] vptr_new;
  logic [7:0]        rab_eff;
  logic [LINE_W-1:0] lc_nxt;
  logic [7:0]        lui_cur;

  assign cmask    = handheld_i ? CMASK_WIDE : CMASK_NARROW;
  assign cptr_inc = (cptr_q + CPTR_W'(1)) & cmask;
  assign vptr_inc = (vptr_q + VPTR_W'(1)) & VPTR_MASK;
  assign vptr_new = {data_i[5:0], latch_q} & VPTR_MASK;
  // The read-ahead value may still sit in the video memory's output register.
  assign rab_eff  = rab_mem_q ? vram_rdata_i : rab_q;
  assign lc_nxt   = (lc_q == LINE_LAST) ? '0 : lc_q + LINE_W'(1);
  assign lui_cur  = (lc_nxt == '0) ? r10_q : lui_q;

  always_comb begin
    pend_d     = pend_q;
    latch_d    = latch_q;
    frame_d    = frame_q;
    line_d     = line_q;
    rab_d      = rab_q;
    rab_mem_d  = rab_mem_q;
    cmode_d    = cmode_q;
    cptr_d     = cptr_q;
    vptr_d     = vptr_q;
    lc_d       = lc_q;
    lui_d      = lui_q;
    irq_d      = irq_q;
    r0_b4_d    = r0_b4_q;
    r1_b5_d    = r1_b5_q;
    r10_d      = r10_q;
    vram_req_o = '0;
    cram_req_o = '0;
    result_o   = '0;

    if (acc_i) begin
      case (cmd_e'(cmd_i))
        CMD_DATA_RD: begin
          if (cmode_q) begin
            cram_req_o.en   = 1'b1;
            cram_req_o.addr = cptr_q[CA_W-1:0];
            result_o.color_rd = 1'b1;
            cptr_d = cptr_inc;
          end else begin
            result_o.rd     = rab_eff;
            vram_req_o.en   = 1'b1;
            vram_req_o.addr = vptr_q[VA_W-1:0];
            rab_mem_d = 1'b1;
            vptr_d    = vptr_inc;
          end
        end
        CMD_DATA_WR: begin
          if (cmode_q) begin
            cram_req_o.en    = 1'b1;
            cram_req_o.we    = 1'b1;
            cram_req_o.addr  = cptr_q[CA_W-1:0];
            cram_req_o.wdata = data_i;
            cptr_d = cptr_inc;
          end else begin
            vram_req_o.en    = 1'b1;
            vram_req_o.we    = 1'b1;
            vram_req_o.addr  = vptr_q[VA_W-1:0];
            vram_req_o.wdata = data_i;
            rab_d     = data_i;
            rab_mem_d = 1'b0;
            vptr_d    = vptr_inc;
          end
        end
        CMD_STATUS_RD: begin
          result_o.rd = {frame_q, line_q, 6'd0};
          pend_d  = 1'b0;
          irq_d   = 1'b0;
          frame_d = 1'b0;
          line_d  = 1'b0;
        end
        CMD_CTRL_WR: begin
          if (!pend_q) begin
            pend_d  = 1'b1;
            latch_d = data_i;
          end else begin
            pend_d = 1'b0;
            if (data_i[7:4] == 4'h8) begin
              // Only the register bits that drive interrupts are kept.
              if (data_i[3:0] == 4'd0) begin
                r0_b4_d = latch_q[4];
              end
              if (data_i[3:0] == 4'd1) begin
                r1_b5_d = latch_q[5];
              end
              if (data_i[3:0] == 4'd10) begin
                r10_d = latch_q;
              end
            end else if (data_i[7:6] == 2'b11) begin
              cptr_d  = latch_q[CPTR_W-1:0] & cmask;
              cmode_d = 1'b1;
            end else begin
              cmode_d = 1'b0;
              vptr_d  = vptr_new;
              if (!data_i[6]) begin
                vram_req_o.en   = 1'b1;
                vram_req_o.addr = vptr_new[VA_W-1:0];
                rab_mem_d = 1'b1;
                vptr_d    = (vptr_new + VPTR_W'(1)) & VPTR_MASK;
              end
            end
          end
        end
        CMD_LINE_TICK: begin
          lc_d = lc_nxt;
          if (lc_nxt >= LINE_VBLANK) begin
            if (lc_nxt < LINE_VBLANK_END && frame_q && r1_b5_q) begin
              irq_d = 1'b1;
            end
          end else begin
            if (lui_cur != 8'd0) begin
              lui_d = lui_cur - 8'd1;
            end else begin
              lui_d  = r10_q;
              line_d = 1'b1;
            end
            if (line_d && r0_b4_q) begin
              irq_d = 1'b1;
            end
            if (lc_nxt == LINE_FRAME) begin
              frame_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result_o.irq  = irq_d;
    result_o.line = lc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      latch_q   <= '0;
      frame_q   <= 1'b0;
      line_q    <= 1'b0;
      rab_q     <= '0;
      rab_mem_q <= 1'b0;
      cmode_q   <= 1'b0;
      cptr_q    <= '0;
      vptr_q    <= '0;
      lc_q      <= '0;
      lui_q     <= '0;
      irq_q     <= 1'b0;
      r0_b4_q   <= 1'b0;
      r1_b5_q   <= 1'b0;
      r10_q     <= '0;
    end else begin
      pend_q    <= pend_d;
      latch_q   <= latch_d;
      frame_q   <= frame_d;
      line_q    <= line_d;
      rab_q     <= rab_d;
      rab_mem_q <= rab_mem_d;
      cmode_q   <= cmode_d;
      cptr_q    <= cptr_d;
      vptr_q    <= vptr_d;
      lc_q      <= lc_d;
      lui_q     <= lui_d;
      irq_q     <= irq_d;
      r0_b4_q   <= r0_b4_d;
      r1_b5_q   <= r1_b5_d;
      r10_q     <= r10_d;
    end
  end

  `VPL_ASSERT_NXT(a_status_clears_irq, acc_i && cmd_i == CMD_STATUS_RD, !irq_q && !pend_q, "status read must clear the interrupt and the pending write")
  `VPL_ASSERT_IMP(a_line_in_range, 1'b1, lc_q <= LINE_LAST, "line counter out of range")
  `VPL_ASSERT_IMP(a_one_mem_access, 1'b1, !(vram_req_o.en && cram_req_o.en), "video and color memory accessed by one transaction")

endmodule
